// ===== design/gblaw_pkg.sv =====
// Shared types and constants of the grid boundary-layer address walker.
`default_nettype none

package gblaw_pkg;

	localparam int CNT_W    = 12;
	localparam int COORD_W  = 14;
	localparam int AXIS_W   = 13;
	localparam int BOUND_W  = 11;
	localparam int SIZE_W   = 25;
	localparam int TS_W     = 16;
	localparam int INDEX_W  = 24;
	localparam int GRID_W   = 36;
	localparam int BACKUP_W = 40;
	localparam int IN_W     = 24;
	localparam int OUT_W    = 80;

	localparam logic [1:0] PH_X    = 2'd0;
	localparam logic [1:0] PH_Z    = 2'd1;
	localparam logic [1:0] PH_Y    = 2'd2;
	localparam logic [1:0] PH_NONE = 2'd3;

	localparam logic [2:0] CFG_ROW_PITCH     = 3'd0;
	localparam logic [2:0] CFG_PLANE_PITCH   = 3'd1;
	localparam logic [2:0] CFG_LOGICAL_NX    = 3'd2;
	localparam logic [2:0] CFG_LOGICAL_NY    = 3'd3;
	localparam logic [2:0] CFG_LOGICAL_NZ    = 3'd4;
	localparam logic [2:0] CFG_BOUND_LENGTH  = 3'd5;
	localparam logic [2:0] CFG_BOUNDARY_SIZE = 3'd6;
	localparam logic [2:0] CFG_IS_3D         = 3'd7;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t ys;
		coord_t ye;
		coord_t zs;
		coord_t ze;
		coord_t xs;
		coord_t xe;
	} range_t;

	typedef struct packed {
		logic       found;
		logic       wrap;
		logic [1:0] phase;
	} settle_t;

endpackage

`default_nettype wire

// ===== design/grid_boundary_layer_address_walker.sv =====
// Top level of the grid boundary-layer address walker.
`default_nettype none

// Each accepted beat yields one element of a mirrored boundary pair: a grid element
// offset and the backup offset snap_step*boundary_size + running index, with tlast on
// the final element of the sweep. A beat is taken every cycle unless the output stalls;
// its result passes through the position update, multiply and final add registers. The
// walk position (phase, y/z/x counters, near/far side, index) is updated in the cycle
// the beat is taken, and that update loop sets the rate. Phases with empty ranges are
// skipped; if all phases are empty, a beat is consumed and gives no result. The user must
// write registers only while no beat is in flight; the block itself does not enforce this.
module grid_boundary_layer_address_walker
	import gblaw_pkg::*;
#(
	parameter int STENCIL_RADIUS = 4,
	parameter int MAX_AXIS       = 4096
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [IN_W-1:0]     s_axis_tdata,   // snap_step[15:0], restart[16]
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [OUT_W-1:0]         m_axis_tdata,   // grid_address[35:0], backup_address[75:36]
	output logic                     m_axis_tlast,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [SIZE_W-1:0]   cfg_wdata
);

	localparam coord_t H_C = COORD_W'(STENCIL_RADIUS);
	localparam logic [AXIS_W-1:0] MAX_C = AXIS_W'(MAX_AXIS);

	// Configuration registers
	logic [AXIS_W-1:0]  row_pitch_q;
	logic [SIZE_W-1:0]  plane_pitch_q;
	logic [AXIS_W-1:0]  nx_q, ny_q, nz_q;
	logic [BOUND_W-1:0] bound_q;
	logic [SIZE_W-1:0]  bsize_q;
	logic               is_3d_q;

	// Walk position
	logic [1:0]         phase_q;
	cnt_t               y_q, z_q, x_q;
	logic               mirror_q;
	logic [INDEX_W-1:0] index_q;

	// Pipeline
	logic               v_s1, v_s2, v_s3;
	coord_t             gy_s1, gz_s1, gx_s1;
	logic [TS_W-1:0]    ts_s1;
	logic [INDEX_W-1:0] ei_s1, ei_s2;
	logic               last_s1, last_s2, last_s3;
	logic [GRID_W-1:0]  py_s2, pz_s2, gx_s2, grid_s3;
	logic [BACKUP_W-1:0] pb_s2, backup_s3;

	logic en1, en2, en3, accept;

	logic [AXIS_W-1:0] lnx, lny, lnz;
	coord_t off, bl_s;
	range_t rng [4];
	logic [3:0] ne;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pitch_q   <= AXIS_W'(64);
			plane_pitch_q <= SIZE_W'(4096);
			nx_q          <= AXIS_W'(64);
			ny_q          <= AXIS_W'(1);
			nz_q          <= AXIS_W'(64);
			bound_q       <= '0;
			bsize_q       <= '0;
			is_3d_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW_PITCH:     row_pitch_q   <= cfg_wdata[AXIS_W-1:0];
				CFG_PLANE_PITCH:   plane_pitch_q <= cfg_wdata;
				CFG_LOGICAL_NX:    nx_q          <= cfg_wdata[AXIS_W-1:0];
				CFG_LOGICAL_NY:    ny_q          <= cfg_wdata[AXIS_W-1:0];
				CFG_LOGICAL_NZ:    nz_q          <= cfg_wdata[AXIS_W-1:0];
				CFG_BOUND_LENGTH:  bound_q       <= cfg_wdata[BOUND_W-1:0];
				CFG_BOUNDARY_SIZE: bsize_q       <= cfg_wdata;
				CFG_IS_3D:         is_3d_q       <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign lnx  = (nx_q > MAX_C) ? MAX_C : nx_q;
	assign lny  = (ny_q > MAX_C) ? MAX_C : ny_q;
	assign lnz  = (nz_q > MAX_C) ? MAX_C : nz_q;
	assign bl_s = {{(COORD_W-BOUND_W){1'b0}}, bound_q};
	assign off  = H_C + bl_s;

	// Ranges of every phase; ends may go negative, which makes the range empty.
	always_comb begin
		range_t base;
		base.ys = is_3d_q ? off : '0;
		base.ye = is_3d_q ? (coord_t'({1'b0, lny}) - off) : coord_t'(1);
		base.zs = off;
		base.ze = coord_t'({1'b0, lnz}) - off;
		base.xs = off;
		base.xe = coord_t'({1'b0, lnx}) - off;
		rng[PH_X] = base;
		rng[PH_X].xs = '0;
		rng[PH_X].xe = H_C;
		rng[PH_Z] = base;
		rng[PH_Z].zs = '0;
		rng[PH_Z].ze = H_C;
		rng[PH_Y] = base;
		rng[PH_Y].ys = '0;
		rng[PH_Y].ye = is_3d_q ? H_C : '0;
		rng[PH_NONE] = base;
		rng[PH_NONE].ys = '0;
		rng[PH_NONE].ye = '0;
		for (int p = 0; p < 4; p++) begin
			ne[p] = (rng[p].ys < rng[p].ye) && (rng[p].zs < rng[p].ze) &&
				(rng[p].xs < rng[p].xe);
		end
	end

	function automatic logic in_range(input range_t r, input cnt_t y, input cnt_t z,
		input cnt_t x);
		coord_t ys, zs, xs;
		ys = coord_t'({2'b0, y});
		zs = coord_t'({2'b0, z});
		xs = coord_t'({2'b0, x});
		return (ys >= r.ys) && (ys < r.ye) && (zs >= r.zs) && (zs < r.ze) &&
			(xs >= r.xs) && (xs < r.xe);
	endfunction

	// Walk forward over phases until one with a non-empty range is found. When every
	// phase is empty the walk still steps five times, which fixes where it is left.
	function automatic settle_t settle(input logic [1:0] p, input logic ok,
		input logic [3:0] nonempty);
		settle_t s;
		logic [1:0] q;
		s.found = ok;
		s.wrap  = 1'b0;
		s.phase = p;
		q = p;
		if (!ok) begin
			for (int i = 0; i < 5; i++) begin
				if (!s.found) begin
					s.wrap  = s.wrap | (q >= PH_Y);
					q       = (q >= PH_Y) ? PH_X : q + 2'd1;
					s.phase = q;
					s.found = nonempty[q];
				end
			end
		end
		return s;
	endfunction

	// Next-state and coordinate logic for the beat being taken.
	logic               restart;
	logic [1:0]         ph_a, ph_b, ph_n;
	cnt_t               y_a, z_a, x_a, y_b, z_b, x_b, y_n, z_n, x_n;
	logic               m_a, m_b, m_n, ok_a, last_n, adv;
	logic [INDEX_W-1:0] ei_a, ei_b, ei_n;
	settle_t            pre, post;
	coord_t             h, ln, mir, gy, gz, gx;
	range_t             r;

	assign restart = s_axis_tdata[TS_W];

	always_comb begin
		ph_a = restart ? PH_X : phase_q;
		y_a  = restart ? rng[PH_X].ys[CNT_W-1:0] : y_q;
		z_a  = restart ? rng[PH_X].zs[CNT_W-1:0] : z_q;
		x_a  = restart ? rng[PH_X].xs[CNT_W-1:0] : x_q;
		m_a  = restart ? 1'b0 : mirror_q;
		ei_a = restart ? '0 : index_q;

		ok_a = in_range(rng[ph_a], y_a, z_a, x_a);
		pre  = settle(ph_a, ok_a, ne);
		ph_b = pre.phase;
		if (ok_a) begin
			y_b = y_a;
			z_b = z_a;
			x_b = x_a;
			m_b = m_a;
		end else begin
			y_b = rng[ph_b].ys[CNT_W-1:0];
			z_b = rng[ph_b].zs[CNT_W-1:0];
			x_b = rng[ph_b].xs[CNT_W-1:0];
			m_b = 1'b0;
		end
		ei_b = pre.wrap ? '0 : ei_a;

		// Mirrored coordinate along the axis that this phase walks.
		gy = coord_t'({2'b0, y_b});
		gz = coord_t'({2'b0, z_b});
		gx = coord_t'({2'b0, x_b});
		if (ph_b == PH_X) begin
			h  = gx;
			ln = coord_t'({1'b0, lnx});
		end else if (ph_b == PH_Z) begin
			h  = gz;
			ln = coord_t'({1'b0, lnz});
		end else begin
			h  = gy;
			ln = coord_t'({1'b0, lny});
		end
		mir = m_b ? (ln - bl_s - coord_t'(1) - h) : (bl_s + h);
		if (ph_b == PH_X) begin
			gx = mir;
		end else if (ph_b == PH_Z) begin
			gz = mir;
		end else begin
			gy = mir;
		end

		r      = rng[ph_b];
		adv    = 1'b0;
		post   = settle(ph_b, 1'b1, ne);
		ph_n   = ph_b;
		y_n    = y_b;
		z_n    = z_b;
		x_n    = x_b;
		m_n    = m_b;
		ei_n   = ei_b;
		last_n = 1'b0;
		if (!pre.found) begin
			// Nothing to walk: the position is left at the start of the last phase tried.
			ei_n = ei_a;
		end else if (!m_b) begin
			m_n  = 1'b1;
			ei_n = ei_b + INDEX_W'(1);
		end else begin
			m_n = 1'b0;
			if (coord_t'({2'b0, x_b}) + coord_t'(1) < r.xe) begin
				x_n = x_b + CNT_W'(1);
			end else begin
				x_n = r.xs[CNT_W-1:0];
				if (coord_t'({2'b0, z_b}) + coord_t'(1) < r.ze) begin
					z_n = z_b + CNT_W'(1);
				end else begin
					z_n = r.zs[CNT_W-1:0];
					if (coord_t'({2'b0, y_b}) + coord_t'(1) < r.ye) begin
						y_n = y_b + CNT_W'(1);
					end else begin
						adv = 1'b1;
					end
				end
			end
			if (adv) begin
				post = settle(ph_b, 1'b0, ne);
				ph_n = post.phase;
				y_n  = rng[post.phase].ys[CNT_W-1:0];
				z_n  = rng[post.phase].zs[CNT_W-1:0];
				x_n  = rng[post.phase].xs[CNT_W-1:0];
			end
			last_n = adv & post.wrap;
			ei_n   = last_n ? '0 : ei_b + INDEX_W'(1);
		end
	end

	assign en3    = !v_s3 || m_axis_tready;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;
	assign accept = s_axis_tvalid && en1;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_X;
			y_q      <= '0;
			z_q      <= CNT_W'(STENCIL_RADIUS);
			x_q      <= '0;
			mirror_q <= 1'b0;
			index_q  <= '0;
		end else if (accept) begin
			phase_q  <= ph_n;
			y_q      <= y_n;
			z_q      <= z_n;
			x_q      <= x_n;
			mirror_q <= m_n;
			index_q  <= ei_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= accept && pre.found;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Products are signed so that a far coordinate below zero wraps like the address.
	logic signed [COORD_W+SIZE_W:0]  prod_y;
	logic signed [COORD_W+AXIS_W:0]  prod_z;
	logic [TS_W+SIZE_W-1:0]          prod_b;

	assign prod_y = gy_s1 * $signed({1'b0, plane_pitch_q});
	assign prod_z = gz_s1 * $signed({1'b0, row_pitch_q});
	assign prod_b = ts_s1 * bsize_q;

	always_ff @(posedge clk) begin
		if (en1) begin
			gy_s1   <= gy;
			gz_s1   <= gz;
			gx_s1   <= gx;
			ts_s1   <= s_axis_tdata[TS_W-1:0];
			ei_s1   <= ei_b;
			last_s1 <= last_n;
		end
		if (en2) begin
			py_s2   <= prod_y[GRID_W-1:0];
			pz_s2   <= {{(GRID_W-COORD_W-AXIS_W-1){prod_z[COORD_W+AXIS_W]}}, prod_z};
			gx_s2   <= {{(GRID_W-COORD_W){gx_s1[COORD_W-1]}}, gx_s1};
			pb_s2   <= prod_b[BACKUP_W-1:0];
			ei_s2   <= ei_s1;
			last_s2 <= last_s1;
		end
		if (en3) begin
			grid_s3   <= py_s2 + pz_s2 + gx_s2;
			backup_s3 <= pb_s2 + {{(BACKUP_W-INDEX_W){1'b0}}, ei_s2};
			last_s3   <= last_s2;
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = {{(OUT_W-GRID_W-BACKUP_W){1'b0}}, backup_s3, grid_s3};
	assign m_axis_tlast  = last_s3;

endmodule

`default_nettype wire
